@@ sv/ibmh_pkg.sv @@
// ----------------------------------------------------------------------------
// ibmh_pkg: shared types and constants for the indexed binary min-heap
// Operation and status codes, sizes of the slot store and the position table.
// ----------------------------------------------------------------------------
package ibmh_pkg;

    localparam int CAPACITY  = 64;
    localparam int ID_COUNT  = 64;
    localparam int KEY_WIDTH = 32;

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int POS_W   = $clog2(2 * CAPACITY);
    localparam int ID_W    = 6;
    localparam int KEY_IN_W = 32;

    localparam logic [POS_W-1:0] ABSENT_MARK = POS_W'(2 * CAPACITY - 1);

    typedef logic [1:0] op_t;
    localparam op_t OP_INSERT  = 2'd0;
    localparam op_t OP_EXTRACT = 2'd1;
    localparam op_t OP_UPDATE  = 2'd2;
    localparam op_t OP_CLEAR   = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_FULL    = 2'd1;
    localparam status_t ST_EMPTY   = 2'd2;
    localparam status_t ST_ABSENT  = 2'd3;

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [ID_W-1:0]      id_t;

endpackage

@@ sv/indexed_binary_min_heap.sv @@
// ----------------------------------------------------------------------------
// indexed_binary_min_heap: priority queue of item ids keyed by unsigned keys
// Binary min-heap in slot memories plus an id-to-slot position table, driven
// by a small sequencer around one shared key comparator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready carries one command beat: s_op (insert,
//   extract minimum, update key, clear), s_item_id and s_item_key.
//   Result channel m_valid/m_ready returns exactly one beat per command:
//   m_status, m_out_id, m_out_key (nonzero only on a successful extract) and
//   m_entry_count, the number of entries after the command.
//   Sift up reads the parent and compares per level; sift down reads the left
//   child, reads the right child, selects the smaller child and compares its
//   key with the moving key per level. A lookup reads the position table,
//   then the slot. The single comparator and the one-read-port slot memory
//   serialise these steps.
//   s_ready is high only while the sequencer is idle and the result register
//   is free, so one command is in flight at a time; the next command can be
//   taken in the cycle after the result beat leaves.
//   When the receiver stalls, hold the result in the output register.
//   Reset (aresetn low, synchronous) empties the heap and starts a sweep
//   that writes the absent mark into all ID_COUNT=64 position table entries;
//   s_ready stays low during the sweep.
// ----------------------------------------------------------------------------
module indexed_binary_min_heap (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_op,
    input  logic [5:0]               s_item_id,
    input  logic [31:0]              s_item_key,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic [5:0]               m_out_id,
    output logic [31:0]              m_out_key,
    output logic [6:0]               m_entry_count
);
    import ibmh_pkg::*;

    typedef enum logic [14:0] {
        S_INIT    = 15'b000000000000001,
        S_IDLE    = 15'b000000000000010,
        S_LOOK    = 15'b000000000000100,  // position table data valid, issue slot read
        S_CHECK   = 15'b000000000001000,  // slot id read, presence test
        S_ROOT    = 15'b000000000010000,  // root read data valid
        S_LAST    = 15'b000000000100000,  // last slot read data valid
        S_UP_RD   = 15'b000000001000000,  // issue parent read
        S_UP_CMP  = 15'b000000010000000,
        S_DN_RDL  = 15'b000000100000000,  // issue left child read
        S_DN_RDR  = 15'b000001000000000,  // left data back, issue right read
        S_DN_CMP  = 15'b000010000000000,  // pick the smaller child
        S_PUT     = 15'b000100000000000,  // place the moving entry
        S_DONE    = 15'b001000000000000,
        S_WAITDN  = 15'b010000000000000,  // after sift up, re-enter sift down
        S_DN_KEY  = 15'b100000000000000   // chosen child against moving key
    } state_t;

    state_t state_reg, state_next;

    // slot memories and the position table
    id_t  slot_ids  [CAPACITY];
    key_t slot_keys [CAPACITY];
    logic [POS_W-1:0] position_of [ID_COUNT];

    // one read port on the slot store, one on the position table
    slot_t            rd_addr;
    logic             rd_en;
    id_t              rd_id_reg;
    key_t             rd_key_reg;
    logic [POS_W-1:0] pos_rd_reg;

    // slot write port
    logic  wr_en;
    slot_t wr_slot;
    id_t   wr_id;
    key_t  wr_key;
    // position table write port
    logic             pw_en;
    id_t              pw_id;
    logic [POS_W-1:0] pw_val;

    // working registers
    op_t     op_reg;
    id_t     id_reg;
    key_t    key_reg;           // key of the moving entry
    id_t     mid_reg;           // id of the moving entry
    slot_t   slot_reg;          // current hole
    cnt_t    count_reg;
    logic    then_down_reg;     // key change of a present id: sift down after sift up
    id_t     lid_reg;           // chosen child entry
    key_t    lkey_reg;
    logic    has_right_reg;
    logic    sel_right_reg;
    status_t st_reg;
    id_t     rid_reg;
    key_t    rkey_reg;
    id_t     init_reg;

    logic    m_valid_reg;
    status_t m_status_reg;
    id_t     m_id_reg;
    key_t    m_key_reg;
    cnt_t    m_cnt_reg;

    // derived addresses
    logic [SLOT_W:0] child_l;
    slot_t           parent;
    assign child_l = {slot_reg, 1'b1};
    assign parent  = (slot_reg - slot_t'(1)) >> 1;

    // shared comparator: a < b
    key_t cmp_a, cmp_b;
    logic cmp_lt;
    assign cmp_lt = cmp_a < cmp_b;

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_id_reg  <= slot_ids[rd_addr];
            rd_key_reg <= slot_keys[rd_addr];
        end
        if (wr_en) begin
            slot_ids[wr_slot]  <= wr_id;
            slot_keys[wr_slot] <= wr_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pos_rd_reg <= position_of[s_item_id];
        end
        if (pw_en) begin
            position_of[pw_id] <= pw_val;
        end
    end

    logic [SLOT_W:0] child_r;
    assign child_r = child_l + 1'b1;

    always_comb begin
        state_next = state_reg;
        rd_en = 1'b0;
        rd_addr = '0;
        wr_en = 1'b0;
        wr_slot = slot_reg;
        wr_id = rd_id_reg;
        wr_key = rd_key_reg;
        pw_en = 1'b0;
        pw_id = rd_id_reg;
        pw_val = POS_W'(slot_reg);
        cmp_a = rd_key_reg;
        cmp_b = key_reg;
        case (state_reg)
            S_UP_CMP: begin
                cmp_a = key_reg;
                cmp_b = rd_key_reg;
            end
            S_DN_CMP: begin
                cmp_a = rd_key_reg;
                cmp_b = lkey_reg;
            end
            S_DN_KEY: begin
                cmp_a = lkey_reg;
                cmp_b = key_reg;
            end
            default: ;
        endcase
        unique case (state_reg)
            S_INIT: begin
                pw_en = 1'b1;
                pw_id = init_reg;
                pw_val = ABSENT_MARK;
                if (init_reg == id_t'(ID_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    unique case (s_op) inside
                        OP_INSERT, OP_UPDATE: state_next = S_LOOK;
                        OP_EXTRACT: begin
                            if (count_reg == '0) begin
                                state_next = S_DONE;
                            end else begin
                                rd_en = 1'b1;
                                rd_addr = '0;
                                state_next = S_ROOT;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_LOOK: begin
                rd_en = 1'b1;
                rd_addr = slot_t'(pos_rd_reg);
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if ((CNT_W'(pos_rd_reg) < count_reg) && (pos_rd_reg[POS_W-1] == 1'b0)
                        && (rd_id_reg == id_reg)) begin
                    // present: treat as key change at that slot
                    state_next = S_UP_RD;
                end else if (op_reg == OP_UPDATE || count_reg == cnt_t'(CAPACITY)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_UP_RD;
                end
            end
            S_ROOT: begin
                pw_en = 1'b1;
                pw_id = rd_id_reg;
                pw_val = ABSENT_MARK;
                if (count_reg == cnt_t'(1)) begin
                    state_next = S_DONE;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = slot_t'(count_reg - cnt_t'(1));
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                state_next = S_DN_RDL;
            end
            S_UP_RD: begin
                if (slot_reg == '0) begin
                    state_next = then_down_reg ? S_WAITDN : S_PUT;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                // cmp: moving key < parent key, else stop
                if (!cmp_lt) begin
                    state_next = then_down_reg ? S_WAITDN : S_PUT;
                end else begin
                    wr_en = 1'b1;
                    pw_en = 1'b1;
                    state_next = S_UP_RD;
                end
            end
            S_WAITDN: begin
                state_next = S_DN_RDL;
            end
            S_DN_RDL: begin
                if (child_l >= (SLOT_W+1)'(count_reg)) begin
                    state_next = S_PUT;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = slot_t'(child_l);
                    state_next = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                if (has_right_reg) begin
                    rd_en = 1'b1;
                    rd_addr = slot_t'(child_r);
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                // cmp: right < left
                state_next = S_DN_KEY;
            end
            S_DN_KEY: begin
                // cmp: chosen child key < moving key, else stop
                if (!cmp_lt) begin
                    state_next = S_PUT;
                end else begin
                    wr_en = 1'b1;
                    wr_id = lid_reg;
                    wr_key = lkey_reg;
                    pw_en = 1'b1;
                    pw_id = lid_reg;
                    state_next = S_DN_RDL;
                end
            end
            S_PUT: begin
                wr_en = 1'b1;
                wr_id = mid_reg;
                wr_key = key_reg;
                pw_en = 1'b1;
                pw_id = mid_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic right_ok;
    assign right_ok = child_r < (SLOT_W+1)'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            init_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT: init_reg <= init_reg + id_t'(1);
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        op_reg   <= s_op;
                        id_reg   <= s_item_id;
                        key_reg  <= key_t'(s_item_key);
                        mid_reg  <= s_item_id;
                        slot_reg <= '0;
                        then_down_reg <= 1'b0;
                        st_reg   <= (s_op == OP_EXTRACT && count_reg == '0) ? ST_EMPTY
                                                                            : ST_OK;
                        rid_reg  <= '0;
                        rkey_reg <= '0;
                        if (s_op == OP_CLEAR) begin
                            count_reg <= '0;
                        end
                    end
                end
                S_CHECK: begin
                    if ((CNT_W'(pos_rd_reg) < count_reg) && (pos_rd_reg[POS_W-1] == 1'b0)
                            && (rd_id_reg == id_reg)) begin
                        slot_reg      <= slot_t'(pos_rd_reg);
                        then_down_reg <= 1'b1;
                    end else if (op_reg == OP_UPDATE) begin
                        st_reg <= ST_ABSENT;
                    end else if (count_reg == cnt_t'(CAPACITY)) begin
                        st_reg <= ST_FULL;
                    end else begin
                        // append at the end, then sift up
                        slot_reg  <= slot_t'(count_reg);
                        count_reg <= count_reg + cnt_t'(1);
                    end
                end
                S_ROOT: begin
                    rid_reg   <= rd_id_reg;
                    rkey_reg  <= rd_key_reg;
                    count_reg <= count_reg - cnt_t'(1);
                end
                S_LAST: begin
                    mid_reg  <= rd_id_reg;
                    key_reg  <= rd_key_reg;
                    slot_reg <= '0;
                end
                S_UP_CMP: begin
                    if (cmp_lt) begin
                        slot_reg <= parent;
                    end
                end
                S_DN_RDL: has_right_reg <= right_ok;
                S_DN_RDR: begin
                    lid_reg  <= rd_id_reg;
                    lkey_reg <= rd_key_reg;
                end
                S_DN_CMP: begin
                    // right child wins only when strictly smaller
                    if (has_right_reg && cmp_lt) begin
                        lid_reg       <= rd_id_reg;
                        lkey_reg      <= rd_key_reg;
                        sel_right_reg <= 1'b1;
                    end else begin
                        sel_right_reg <= 1'b0;
                    end
                end
                S_DN_KEY: begin
                    if (cmp_lt) begin
                        slot_reg <= sel_right_reg ? slot_t'(child_r) : slot_t'(child_l);
                    end
                end
                S_DONE: begin
                    m_valid_reg  <= 1'b1;
                    m_status_reg <= st_reg;
                    m_id_reg     <= rid_reg;
                    m_key_reg    <= rkey_reg;
                    m_cnt_reg    <= count_reg;
                end
                default: ;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_id      = m_id_reg;
    assign m_out_key     = 32'(m_key_reg);
    assign m_entry_count = 7'(m_cnt_reg);

    // the heap never holds more than its capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cnt_t'(CAPACITY))
        else $error("entry count above capacity");

    // a result is produced only from the closing state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result without finished command");

    // no command is taken while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !s_ready)
        else $error("ready while result pending");

    // a failed command reports a zero id and key
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |-> (m_id_reg == '0 && m_key_reg == '0))
        else $error("payload on failed command");

endmodule
